FILE: rtl/sipd_pkg.sv
package sipd_pkg;

    // Character codes and fixed sizes
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam int         RADIX    = 10;
    localparam int         DIGITS   = 10;
    localparam int         MAG_BITS = 32;

    // One request on the input channel
    typedef struct packed {
        logic signed [31:0] value;
        logic        [4:0]  width;
        logic        [7:0]  fill_char;
    } in_item_t;

    // One character on the result channel
    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
    } out_item_t;

    // Classified request handed from the front end to the converter
    typedef struct packed {
        logic                neg;
        logic [MAG_BITS-1:0] mag;
        logic [7:0]          fill;
    } conv_req_t;

endpackage

FILE: rtl/signed_int_to_padded_decimal.sv
// Path from an accepted request to its first character: queue exit, 32
// double-dabble steps, field sizing, output register.
// The bit-serial digit converter takes the next number only after the last
// character of the current one (1 to MAX_WIDTH characters) has been issued.
// A two-entry queue takes up to two more requests while one is converted.
// Reset (aresetn, synchronous, active low) empties the queue and output.
module signed_int_to_padded_decimal #(
    parameter int MAX_WIDTH = 26
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sipd_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sipd_pkg::out_item_t m_data
);
    import sipd_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int QW = $bits(conv_req_t) + WW;

    conv_req_t     f_req, q_req;
    logic [WW-1:0] f_width, q_width;
    logic [QW-1:0] q_rd_data;
    logic          q_rd_valid, q_rd_ready;

    // Classify each request
    sipd_front #(.MAX_WIDTH(MAX_WIDTH), .WW(WW)) u_front (
        .in_item   (s_data),
        .req       (f_req),
        .req_width (f_width)
    );

    // Decouple classification from conversion
    sipd_fifo #(.WIDTH(QW), .DEPTH(2)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  ({f_req, f_width}),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    assign q_req   = q_rd_data[QW-1:WW];
    assign q_width = q_rd_data[WW-1:0];

    // Convert and emit characters
    sipd_back #(.WW(WW)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_req   (q_req),
        .rd_width (q_width),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // Queue and output come out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !q_rd_valid))
        else $error("queue or output not empty after reset");

    // An accepted request is visible to the converter next cycle
    a_queue_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> q_rd_valid)
        else $error("accepted request missing from queue");

    // Characters of one number follow without bubbles
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last) |=> m_valid)
        else $error("gap inside a number");

endmodule

FILE: rtl/sipd_front.sv
module sipd_front #(
    parameter int MAX_WIDTH = 26,
    parameter int WW        = 5
) (
    input  sipd_pkg::in_item_t  in_item,
    output sipd_pkg::conv_req_t req,
    output logic [WW-1:0]       req_width
);
    import sipd_pkg::*;

    localparam int CW = (WW > 5) ? WW : 5;

    logic [MAG_BITS-1:0] raw;
    logic [CW-1:0]       w_ext;

    // Split off the sign and take the unsigned magnitude
    assign raw       = MAG_BITS'(in_item.value);
    assign req.neg   = raw[MAG_BITS-1];
    assign req.mag   = raw[MAG_BITS-1] ? (MAG_BITS'(0) - raw) : raw;
    assign req.fill  = in_item.fill_char;

    // Clip the field width to the supported maximum
    assign w_ext     = CW'(in_item.width);
    assign req_width = (w_ext > CW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w_ext);

endmodule

FILE: rtl/sipd_fifo.sv
module sipd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    localparam int PW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic             push, pop;

    assign wr_ready = (count_reg != CNTW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/sipd_back.sv
module sipd_back #(
    parameter int WW        = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_valid,
    output logic                 rd_ready,
    input  sipd_pkg::conv_req_t  rd_req,
    input  logic [WW-1:0]        rd_width,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sipd_pkg::out_item_t  m_data
);
    import sipd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_LEN  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;
    localparam int         SW      = $clog2(MAG_BITS);

    logic [1:0]               state_reg, state_next;
    logic [SW-1:0]            step_reg, step_next;
    logic [MAG_BITS-1:0]      bin_reg, bin_next;
    logic [DIGITS-1:0][3:0]   bcd_reg, bcd_next;
    logic                     neg_reg, neg_next;
    logic [7:0]               fill_reg, fill_next;
    logic [WW-1:0]            width_reg, width_next;
    logic [WW-1:0]            total_reg, total_next;
    logic [WW-1:0]            lead_reg, lead_next;
    logic [WW-1:0]            k_reg, k_next;
    logic                     m_valid_reg, m_valid_next;
    out_item_t                m_data_reg, m_data_next;

    logic [DIGITS-1:0][3:0]   adj;
    logic [3:0]               nd;
    logic [WW-1:0]            len_min;
    logic [3:0]               di;
    logic                     slot_free;
    logic                     is_last;
    logic [7:0]               ch;

    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign rd_ready  = (state_reg == ST_IDLE);
    assign slot_free = !m_valid_reg || m_ready;

    // Add three to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    // Count significant digits; zero still has one
    always_comb begin
        nd = 4'd1;
        for (int i = 1; i < DIGITS; i++) begin
            if (bcd_reg[i] != 4'd0) begin
                nd = 4'(i + 1);
            end
        end
    end

    assign len_min = WW'(nd) + WW'(neg_reg);

    // Pick the character at the current position
    assign di      = 4'(total_reg - k_reg - 1'b1);
    assign is_last = (k_reg == total_reg - 1'b1);
    always_comb begin
        if (neg_reg && (k_reg == '0)) begin
            ch = CH_MINUS;
        end else if (k_reg < lead_reg) begin
            ch = fill_reg;
        end else begin
            ch = CH_ZERO + {4'd0, bcd_reg[di]};
        end
    end

    // Sequencer: load, double-dabble, size the field, emit
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        fill_next    = fill_reg;
        width_next   = width_reg;
        total_next   = total_reg;
        lead_next    = lead_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (rd_valid) begin
                    bin_next   = rd_req.mag;
                    bcd_next   = '0;
                    neg_next   = rd_req.neg;
                    fill_next  = rd_req.fill;
                    width_next = rd_width;
                    step_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next  = {adj[DIGITS-1][2:0], adj[DIGITS-2:0], bin_reg[MAG_BITS-1]};
                bin_next  = {bin_reg[MAG_BITS-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(MAG_BITS - 1)) begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                total_next = (width_reg > len_min) ? width_reg : len_min;
                lead_next  = ((width_reg > len_min) ? width_reg : len_min) - WW'(nd);
                k_next     = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.char_out = ch;
                    m_data_next.last     = is_last;
                    k_next               = k_reg + 1'b1;
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold datapath registers
    always_ff @(posedge aclk) begin
        step_reg   <= step_next;
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        neg_reg    <= neg_next;
        fill_reg   <= fill_next;
        width_reg  <= width_next;
        total_reg  <= total_next;
        lead_reg   <= lead_next;
        k_reg      <= k_next;
        m_data_reg <= m_data_next;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
